>>> rtl/tts_pkg.sv
// Shared types, constants and helpers for the tournament tree sorter.
package tts_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int MAX_GRADES  = 4;
	localparam int GRADE_W     = 10;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int NODE_W      = 7;
	localparam int NG_W        = 3;
	localparam int DEPTH_W     = 3;
	localparam int TREE_NODES  = 2 * MAX_RECORDS;

	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_KIDS,
		S_REC,
		S_CMP,
		S_TIE,
		S_EM_RD,
		S_EM_REC,
		S_EM_OUT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic kids;
		logic root;
		logic rec;
		logic cmp;
		logic tie_wr;
		logic node_dec;
		logic climb;
		logic out_load;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic p_root;
		logic depth_zero;
		logic all_done;
		logic emit_last;
		logic out_free;
	} stat_t;

	// smallest d with 2^d >= n, capped at 6
	function automatic logic [DEPTH_W-1:0] depth_of(input logic [CNT_W-1:0] n);
		logic [DEPTH_W-1:0] d;
		d = 3'd6;
		if (n <= 7'd32) d = 3'd5;
		if (n <= 7'd16) d = 3'd4;
		if (n <= 7'd8)  d = 3'd3;
		if (n <= 7'd4)  d = 3'd2;
		if (n <= 7'd2)  d = 3'd1;
		if (n <= 7'd1)  d = 3'd0;
		return d;
	endfunction

	function automatic logic [NG_W-1:0] grades_used(input logic [NG_W-1:0] ng);
		return (ng > NG_W'(MAX_GRADES)) ? NG_W'(MAX_GRADES) : ng;
	endfunction

endpackage

>>> rtl/tournament_tree_sorter.sv
// Top level of the tournament tree sorter.
// Input channel (in_valid/in_ready): one record word per cycle while loading,
// up to 64 stored; more are dropped. A word with last_record set starts the
// sort and in_ready stays low until the last result has been issued and its
// path replayed.
// Config channel (cfg_valid/cfg_ready, cfg_data): num_grades, always ready,
// reset value 4; write it only while idle.
// Output channel (out_valid/out_ready): one word per record in descending
// order with rank, load index, average, tie-break grade and last flag.
// Sorting n records with leaves = 2^d: the build plays every match of the
// tree (a single record skips it), then each result takes a root read, a
// record read and an output load, followed by a replay of the d matches on
// its path, and a finish step closes the sort; every match is four passes
// through the single compare unit (tree read, record read, compare, tie update).
// A stalled receiver holds the sequencer in the emit step; one result waits
// in the output register while the next is being fetched.
// Reset empties the tree, clears the count and sets num_grades to 4.
module tournament_tree_sorter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tts_pkg::NG_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tts_pkg::GRADE_W-1:0]   student_average,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_first,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_second,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_third,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_fourth,
	input  logic                          last_record,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tts_pkg::CNT_W-1:0]     rank,
	output logic [tts_pkg::IDX_W-1:0]     record_index,
	output logic [tts_pkg::GRADE_W-1:0]   winner_average,
	output logic [tts_pkg::NG_W-1:0]      tie_break_grade,
	output logic                          last_result
);

	tts_pkg::cmd_t  cmd;
	tts_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last_record),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tts_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.student_average (student_average),
		.grade_first     (grade_first),
		.grade_second    (grade_second),
		.grade_third     (grade_third),
		.grade_fourth    (grade_fourth),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.rank            (rank),
		.record_index    (record_index),
		.winner_average  (winner_average),
		.tie_break_grade (tie_break_grade),
		.last_result     (last_result)
	);

endmodule

>>> rtl/tts_ctrl.sv
// Sequencer: load, tree build, emit and path replay.
module tts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  tts_pkg::stat_t   stat,
	output tts_pkg::cmd_t    cmd
);

	tts_pkg::state_t state_q, state_n;
	logic replay_q, replay_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tts_pkg::S_LOAD;
			replay_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			replay_q <= replay_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		replay_n = replay_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tts_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_n = tts_pkg::S_START;
				end
			end
			tts_pkg::S_START: begin
				cmd.start = 1'b1;
				replay_n  = 1'b0;
				state_n   = tts_pkg::S_KIDS;
			end
			tts_pkg::S_KIDS: begin
				// a single record leaves no match to play
				if (!replay_q && stat.depth_zero) begin
					state_n = tts_pkg::S_EM_RD;
				end else begin
					cmd.kids = 1'b1;
					state_n  = tts_pkg::S_REC;
				end
			end
			tts_pkg::S_REC: begin
				cmd.rec = 1'b1;
				state_n = tts_pkg::S_CMP;
			end
			tts_pkg::S_CMP: begin
				cmd.cmp = 1'b1;
				state_n = tts_pkg::S_TIE;
			end
			tts_pkg::S_TIE: begin
				cmd.tie_wr = 1'b1;
				if (stat.p_root) begin
					if (replay_q && stat.all_done) state_n = tts_pkg::S_FIN;
					else state_n = tts_pkg::S_EM_RD;
				end else begin
					if (replay_q) cmd.climb = 1'b1;
					else cmd.node_dec = 1'b1;
					state_n = tts_pkg::S_KIDS;
				end
			end
			tts_pkg::S_EM_RD: begin
				cmd.root = 1'b1;
				state_n  = tts_pkg::S_EM_REC;
			end
			tts_pkg::S_EM_REC: begin
				cmd.rec = 1'b1;
				state_n = tts_pkg::S_EM_OUT;
			end
			tts_pkg::S_EM_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					replay_n     = 1'b1;
					if (stat.depth_zero) begin
						state_n = stat.emit_last ? tts_pkg::S_FIN : tts_pkg::S_EM_RD;
					end else begin
						state_n = tts_pkg::S_KIDS;
					end
				end
			end
			tts_pkg::S_FIN: begin
				cmd.finish = 1'b1;
				state_n    = tts_pkg::S_LOAD;
			end
			default: state_n = tts_pkg::S_LOAD;
		endcase
	end

endmodule

>>> rtl/tts_dp.sv
// Datapath: record stores, winner tree, match compare and result register.
module tts_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tts_pkg::cmd_t                 cmd,
	output tts_pkg::stat_t                stat,
	input  logic                          cfg_valid,
	input  logic [tts_pkg::NG_W-1:0]      cfg_data,
	input  logic [tts_pkg::GRADE_W-1:0]   student_average,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_first,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_second,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_third,
	input  logic [tts_pkg::GRADE_W-1:0]   grade_fourth,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tts_pkg::CNT_W-1:0]     rank,
	output logic [tts_pkg::IDX_W-1:0]     record_index,
	output logic [tts_pkg::GRADE_W-1:0]   winner_average,
	output logic [tts_pkg::NG_W-1:0]      tie_break_grade,
	output logic                          last_result
);

	localparam int GW  = tts_pkg::GRADE_W;
	localparam int IW  = tts_pkg::IDX_W;
	localparam int CW  = tts_pkg::CNT_W;
	localparam int NW  = tts_pkg::NODE_W;
	localparam int GSW = GW * tts_pkg::MAX_GRADES;

	logic [tts_pkg::NG_W-1:0] num_grades_q;
	logic [CW-1:0] count_q, n_q, k_q;
	logic [tts_pkg::DEPTH_W-1:0] depth_q;
	logic [NW-1:0] leaves_q;
	logic [IW-1:0] p_q;

	logic [GW-1:0]  avg_mem   [tts_pkg::MAX_RECORDS];
	logic [GSW-1:0] grade_mem [tts_pkg::MAX_RECORDS];
	logic [IW-1:0]  tree_mem  [tts_pkg::MAX_RECORDS];
	logic [tts_pkg::NG_W-1:0] tie_mem [tts_pkg::MAX_RECORDS];
	logic [tts_pkg::TREE_NODES-1:0] node_v_q;
	logic [tts_pkg::MAX_RECORDS-1:0] tie_v_q;

	logic [NW-1:0] ca_q, cb_q, ca_n, cb_n;
	logic [IW-1:0] ta_q, tb_q, ka, kb;
	logic va_q, vb_q;
	logic [GW-1:0] avga_q, avgb_q;
	logic [GSW-1:0] ga_q, gb_q;
	logic [tts_pkg::NG_W-1:0] tie_rd_q, tj_q, tj, gu, tie_old;
	logic tie_vb_q, tdo_q, tdo, pv, found;
	logic [IW-1:0] win, win_q, tie_addr;
	logic [tts_pkg::DEPTH_W-1:0] st_depth;
	logic [NW-1:0] st_leaves;
	logic [NW:0] st_end;
	logic [NW-1:0] leaf_pos;

	// start-of-sort geometry
	assign st_depth  = tts_pkg::depth_of(count_q);
	assign st_leaves = NW'(1) << st_depth;
	assign st_end    = {1'b0, st_leaves} + {1'b0, count_q};

	assign ca_n = cmd.root ? NW'(1) : {p_q, 1'b0};
	assign cb_n = cmd.root ? NW'(1) : {p_q, 1'b1};

	// leaves hold their own load index
	assign ka = (ca_q >= leaves_q) ? (ca_q[IW-1:0] & IW'(leaves_q - NW'(1))) : ta_q;
	assign kb = (cb_q >= leaves_q) ? (cb_q[IW-1:0] & IW'(leaves_q - NW'(1))) : tb_q;
	assign leaf_pos = leaves_q | {1'b0, ka};

	assign gu = tts_pkg::grades_used(num_grades_q);

	always_comb begin
		win   = ka;
		pv    = 1'b1;
		tdo   = 1'b0;
		tj    = '0;
		found = 1'b0;
		if (!va_q && !vb_q) begin
			pv  = 1'b0;
			win = '0;
		end else if (!vb_q) begin
			win = ka;
		end else if (!va_q) begin
			win = kb;
		end else if (avga_q != avgb_q) begin
			win = (avga_q > avgb_q) ? ka : kb;
		end else begin
			for (int j = 0; j < tts_pkg::MAX_GRADES; j++) begin
				if (!found && (tts_pkg::NG_W'(j) < gu) &&
				    (ga_q[GW*j +: GW] != gb_q[GW*j +: GW])) begin
					found = 1'b1;
					tdo   = 1'b1;
					tj    = tts_pkg::NG_W'(j + 1);
					win   = (ga_q[GW*j +: GW] > gb_q[GW*j +: GW]) ? ka : kb;
				end
			end
		end
	end

	assign tie_addr = cmd.cmp ? win : ka;
	assign tie_old  = tie_vb_q ? tie_rd_q : '0;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CW'(tts_pkg::MAX_RECORDS)) begin
			avg_mem[count_q[IW-1:0]]   <= student_average;
			grade_mem[count_q[IW-1:0]] <= {grade_fourth, grade_third, grade_second, grade_first};
		end
		if (cmd.cmp) tree_mem[p_q] <= win;
		if (cmd.tie_wr && tdo_q && tie_old < tj_q) tie_mem[win_q] <= tj_q;
		if (cmd.kids || cmd.root) begin
			ta_q <= tree_mem[ca_n[IW-1:0]];
			tb_q <= tree_mem[cb_n[IW-1:0]];
		end
		if (cmd.rec) begin
			avga_q <= avg_mem[ka];
			avgb_q <= avg_mem[kb];
			ga_q   <= grade_mem[ka];
			gb_q   <= grade_mem[kb];
		end
		if (cmd.cmp || cmd.rec) tie_rd_q <= tie_mem[tie_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.kids || cmd.root) begin
			ca_q <= ca_n;
			cb_q <= cb_n;
			va_q <= node_v_q[ca_n];
			vb_q <= node_v_q[cb_n];
		end
		if (cmd.cmp || cmd.rec) tie_vb_q <= tie_v_q[tie_addr];
		if (cmd.cmp) begin
			win_q <= win;
			tdo_q <= tdo;
			tj_q  <= tj;
		end
		if (cmd.out_load) begin
			rank            <= k_q + CW'(1);
			record_index    <= ka;
			winner_average  <= avga_q;
			tie_break_grade <= tie_old;
			last_result     <= (k_q + CW'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_grades_q <= tts_pkg::NG_W'(tts_pkg::MAX_GRADES);
			count_q      <= '0;
			n_q          <= '0;
			k_q          <= '0;
			depth_q      <= '0;
			leaves_q     <= NW'(1);
			p_q          <= '0;
			node_v_q     <= '0;
			tie_v_q      <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_valid) num_grades_q <= cfg_data;
			if (cmd.load && count_q < CW'(tts_pkg::MAX_RECORDS)) count_q <= count_q + CW'(1);
			if (cmd.start) begin
				n_q      <= count_q;
				k_q      <= '0;
				depth_q  <= st_depth;
				leaves_q <= st_leaves;
				p_q      <= IW'(st_leaves - NW'(1));
				tie_v_q  <= '0;
				for (int i = 0; i < tts_pkg::TREE_NODES; i++)
					node_v_q[i] <= ((NW+1)'(i) >= {1'b0, st_leaves}) && ((NW+1)'(i) < st_end);
			end
			if (cmd.cmp) node_v_q[{1'b0, p_q}] <= pv;
			if (cmd.tie_wr && tdo_q && tie_old < tj_q) tie_v_q[win_q] <= 1'b1;
			if (cmd.node_dec) p_q <= p_q - IW'(1);
			if (cmd.climb) p_q <= p_q >> 1;
			if (cmd.out_load) begin
				k_q                <= k_q + CW'(1);
				node_v_q[leaf_pos] <= 1'b0;
				p_q                <= leaf_pos[NW-1:1];
			end
			if (cmd.finish) begin
				count_q  <= '0;
				node_v_q <= '0;
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign stat.p_root     = (p_q == IW'(1));
	assign stat.depth_zero = (depth_q == '0);
	assign stat.all_done   = (k_q == n_q);
	assign stat.emit_last  = (k_q + CW'(1) == n_q);
	assign stat.out_free   = !out_valid || out_ready;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(tts_pkg::MAX_RECORDS))
		else $error("record count above capacity");
	a_match_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.kids |-> p_q != '0)
		else $error("match issued at node zero");
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> k_q < n_q)
		else $error("more results than records");
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> count_q == '0 && node_v_q == '0)
		else $error("tree not cleared after sort");

endmodule

>>> tb/tb_tournament_tree_sorter.sv
// Self-checking testbench for the tournament tree sorter: random loads, scoreboard of ranked words.
`timescale 1ns / 100ps

module tb_tournament_tree_sorter;

	typedef struct {
		bit        is_cfg;
		bit [2:0]  ng;
		bit [9:0]  avg;
		bit [9:0]  g1, g2, g3, g4;
		bit        last;
	} word_t;

	typedef struct {
		bit [6:0] rank;
		bit [5:0] idx;
		bit [9:0] avg;
		bit [2:0] tie;
		bit       last;
	} rank_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [2:0] cfg_data = 0;
	logic       in_valid = 0;
	logic       in_ready;
	logic [9:0] student_average = 0, grade_first = 0, grade_second = 0;
	logic [9:0] grade_third = 0, grade_fourth = 0;
	logic       last_record = 0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [6:0] rank;
	logic [5:0] record_index;
	logic [9:0] winner_average;
	logic [2:0] tie_break_grade;
	logic       last_result;

	tournament_tree_sorter dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.in_valid, .in_ready, .student_average, .grade_first, .grade_second,
		.grade_third, .grade_fourth, .last_record,
		.out_valid, .out_ready, .rank, .record_index, .winner_average,
		.tie_break_grade, .last_result
	);

	always #5 clk = ~clk;

	word_t pending[$];
	rank_t ranked_exp[$];
	int errors = 0, n_words = 0, n_ranked = 0, n_loads = 0, n_cfg = 0;

	// sorter model state
	bit       m_tv[128];
	bit [5:0] m_tw[128];
	bit [9:0] m_avg[64];
	bit [9:0] m_grd[64][4];
	bit [2:0] m_tie[64];
	int       m_cnt = 0;
	bit [2:0] m_ng = 3'd4;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void play_match(input int r);
		int l, p, a, b, w, g;
		l = (r - 1) & 127;
		p = ((r - 1) / 2) & 127;
		r = r & 127;
		if (!m_tv[l] && !m_tv[r]) begin
			m_tv[p] = 0;
			m_tw[p] = 0;
			return;
		end
		if (!m_tv[l] || !m_tv[r]) begin
			m_tv[p] = 1;
			m_tw[p] = m_tv[l] ? m_tw[l] : m_tw[r];
			return;
		end
		a = m_tw[l];
		b = m_tw[r];
		w = a;
		if (m_avg[a] != m_avg[b]) begin
			w = (m_avg[a] > m_avg[b]) ? a : b;
		end else begin
			g = (m_ng > tts_pkg::MAX_GRADES) ? tts_pkg::MAX_GRADES : m_ng;
			for (int j = 0; j < g; j++) begin
				if (m_grd[a][j] != m_grd[b][j]) begin
					w = (m_grd[a][j] > m_grd[b][j]) ? a : b;
					if (m_tie[w] < j + 1) m_tie[w] = 3'(j + 1);
					break;
				end
			end
		end
		m_tv[p] = 1;
		m_tw[p] = 6'(w);
	endfunction

	function automatic void rank_records();
		int depth, leaves, pos, w;
		rank_t e;
		depth = 0;
		while ((1 << depth) < m_cnt && depth < 6) depth++;
		leaves = 1 << depth;
		for (int i = 0; i < 128; i++) begin
			m_tv[i] = 0;
			m_tw[i] = 0;
		end
		for (int i = 0; i < 64; i++) m_tie[i] = 0;
		for (int i = 0; i < m_cnt; i++) begin
			m_tv[leaves + i] = 1;
			m_tw[leaves + i] = 6'(i);
		end
		for (int i = leaves - 1; i >= 1; i--) play_match(2 * i + 1);
		for (int k = 0; k < m_cnt; k++) begin
			w = m_tw[1];
			e.rank = 7'(k + 1);
			e.idx = 6'(w);
			e.avg = m_avg[w];
			e.tie = m_tie[w];
			e.last = (k + 1 == m_cnt);
			ranked_exp.push_back(e);
			pos = leaves + w;
			m_tv[pos] = 0;
			m_tw[pos] = 0;
			for (int i = 0; i < depth; i++) begin
				if ((pos & 1) == 0) pos++;
				play_match(pos);
				pos = (pos - 1) / 2;
			end
		end
		m_cnt = 0;
	endfunction

	function automatic void take_record(input word_t w);
		if (m_cnt < 64) begin
			m_avg[m_cnt] = w.avg;
			m_grd[m_cnt][0] = w.g1;
			m_grd[m_cnt][1] = w.g2;
			m_grd[m_cnt][2] = w.g3;
			m_grd[m_cnt][3] = w.g4;
			m_cnt++;
		end
		if (w.last) begin
			rank_records();
			n_loads++;
		end
	endfunction

	// driver: bursts with gaps, config only when the sorter is quiet
	int gap = 0, burst = 0, quiet = 0;
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		bit nxt_in, nxt_cfg, busy;
		if (!arst_n) begin
			in_valid <= 0;
			cfg_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				take_record(pending.pop_front());
				n_words++;
			end
			if (cfg_valid && cfg_ready) begin
				m_ng = pending.pop_front().ng;
				n_cfg++;
			end
			quiet = (ranked_exp.size() == 0 && !out_valid && in_ready) ? quiet + 1 : 0;
			busy = (in_valid && !in_ready) || (cfg_valid && !cfg_ready);
			nxt_in = in_valid && !in_ready;
			nxt_cfg = cfg_valid && !cfg_ready;
			if (!busy) begin
				if (gap > 0) begin
					gap--;
				end else if (pending.size() > 0) begin
					w = pending[0];
					if (w.is_cfg) begin
						if (quiet >= 16) begin
							nxt_cfg = 1;
							cfg_data <= w.ng;
						end
					end else begin
						nxt_in = 1;
						student_average <= w.avg;
						grade_first <= w.g1;
						grade_second <= w.g2;
						grade_third <= w.g3;
						grade_fourth <= w.g4;
						last_record <= w.last;
						if (burst > 0) begin
							burst--;
						end else begin
							burst = $urandom_range(0, 12);
							gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end
					end
				end
			end
			in_valid <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	// receiver stall pattern, mode picked at random by a free-running counter
	int stall_mode = 0, stall_cnt = 0;
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1;
			1: out_ready <= ($urandom_range(0, 1) == 0);
			2: out_ready <= ($urandom_range(0, 9) == 0);
			default: out_ready <= (stall_cnt % 8) < 5;
		endcase
	end

	// monitor
	always @(posedge clk) begin
		rank_t e;
		if (arst_n && out_valid && out_ready) begin
			n_ranked++;
			if (ranked_exp.size() == 0) begin
				report("unexpected word, rank", rank, 0);
			end else begin
				e = ranked_exp.pop_front();
				if (rank != e.rank) report("rank", rank, e.rank);
				if (record_index != e.idx) report("record_index", record_index, e.idx);
				if (winner_average != e.avg) report("winner_average", winner_average, e.avg);
				if (tie_break_grade != e.tie) report("tie_break_grade", tie_break_grade, e.tie);
				if (last_result != e.last) report("last_result", last_result, e.last);
			end
		end
	end

	function automatic void queue_cfg(input bit [2:0] ng);
		word_t w;
		w = '{default: 0};
		w.is_cfg = 1;
		w.ng = ng;
		pending.push_back(w);
	endfunction

	function automatic void queue_rec(input int a, g1, g2, g3, g4, input bit last);
		word_t w;
		w = '{default: 0};
		w.avg = 10'(a);
		w.g1 = 10'(g1);
		w.g2 = 10'(g2);
		w.g3 = 10'(g3);
		w.g4 = 10'(g4);
		w.last = last;
		pending.push_back(w);
	endfunction

	function automatic int pick(input int mode);
		if (mode == 0) return $urandom_range(0, 1000);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1000;
			2: return 511;
			3: return 512;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic void queue_load(input int n);
		int mode;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			queue_rec(pick(mode), pick(mode), pick(mode), pick(mode), pick(mode), i == n - 1);
	endfunction

	initial begin
		int total, n;
		// single record, extreme values
		queue_rec(1000, 0, 1000, 0, 1000, 1);
		// equal averages split on the third and fourth grades, and one full tie
		queue_rec(700, 5, 5, 5, 1, 0);
		queue_rec(700, 5, 5, 5, 9, 0);
		queue_rec(700, 5, 5, 6, 0, 0);
		queue_rec(0, 1000, 1000, 1000, 1000, 0);
		queue_rec(700, 5, 5, 5, 9, 1);
		// one grade only: equal first grades give full ties
		queue_cfg(3'd1);
		queue_rec(300, 7, 1, 0, 0, 0);
		queue_rec(300, 7, 2, 0, 0, 0);
		queue_rec(300, 8, 0, 0, 0, 1);
		// no grades compared
		queue_cfg(3'd0);
		queue_rec(300, 1, 0, 0, 0, 0);
		queue_rec(300, 9, 0, 0, 0, 1);
		// count above the maximum, and empty slots in a 3-record tree
		queue_cfg(3'd7);
		queue_rec(123, 4, 4, 4, 2, 0);
		queue_rec(123, 4, 4, 4, 3, 0);
		queue_rec(124, 0, 0, 0, 0, 1);
		queue_cfg(3'd2);
		queue_rec(1, 1, 2, 0, 0, 0);
		queue_rec(1, 1, 3, 0, 0, 1);
		total = 16;
		while (total < 280) begin
			if ($urandom_range(0, 3) == 0) queue_cfg(3'($urandom_range(0, 7)));
			case ($urandom_range(0, 19))
				0: n = $urandom_range(33, 64);
				1: n = $urandom_range(65, 70);
				default: n = $urandom_range(1, 12);
			endcase
			queue_load(n);
			total += n;
		end
		queue_cfg(3'd4);
		queue_load(64);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0 && ranked_exp.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d record words in %0d loads, %0d num_grades writes", n_words, n_loads, n_cfg);
		$display("%0d ranked words checked, %0d mismatches", n_ranked, errors);
		if (errors == 0 && ranked_exp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout: %0d words still expected", ranked_exp.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/tts_pkg.sv
rtl/tts_ctrl.sv
rtl/tts_dp.sv
rtl/tournament_tree_sorter.sv
tb/tb_tournament_tree_sorter.sv
